>>> design/time_table_linear_interpolator_core_macros.svh
`ifndef TIME_TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define TIME_TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define TTLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TTLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TTLI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TTLI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/ttli_pkg.sv
package ttli_pkg;

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_QUERY  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] ST_POSITION = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        stamp;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
  } ttli_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } ttli_out_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [31:0] x;
    logic [31:0] y;
  } ttli_entry_t;

  typedef struct packed {
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] elapsed;
    logic [31:0] span;
  } ttli_interp_req_t;

endpackage

>>> design/ttli_table_mem.sv
module ttli_table_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  ttli_pkg::ttli_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output ttli_pkg::ttli_entry_t rdata_o
);
  import ttli_pkg::*;

  ttli_entry_t mem_q [DEPTH];
  ttli_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/ttli_interp_unit.sv
module ttli_interp_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  ttli_pkg::ttli_interp_req_t req_i,
  output logic                      done_o,
  output logic [31:0]               res_o
);
  import ttli_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;
  localparam logic [6:0] MUL_LAST = 7'd31;
  localparam logic [6:0] DIV_LAST = 7'd64;

  logic [1:0]  state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic        neg_q, neg_d;
  logic [31:0] v0_q, v0_d;
  logic [31:0] span_q, span_d;
  logic [31:0] el_q, el_d;
  logic [32:0] mag_q, mag_d;
  logic [64:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] quo_q, quo_d;
  logic [31:0] res_q, res_d;

  logic [32:0] diff;
  logic [32:0] rem_sh;
  logic [32:0] delta;
  logic [32:0] sum;

  assign diff   = {req_i.v1[31], req_i.v1} - {req_i.v0[31], req_i.v0};
  assign rem_sh = {rem_q, acc_q[64]};
  assign delta  = neg_q ? (33'd0 - quo_q) : quo_q;
  assign sum    = {v0_q[31], v0_q} + delta;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    neg_d   = neg_q;
    v0_d    = v0_q;
    span_d  = span_q;
    el_d    = el_q;
    mag_d   = mag_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          neg_d  = diff[32];
          mag_d  = diff[32] ? (33'd0 - diff) : diff;
          v0_d   = req_i.v0;
          span_d = req_i.span;
          el_d   = req_i.elapsed;
          acc_d  = '0;
          rem_d  = '0;
          quo_d  = '0;
          cnt_d  = '0;
          if (req_i.span == 32'd0) begin
            res_d   = req_i.v0;
            done_d  = 1'b1;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        acc_d = {acc_q[63:0], 1'b0} + (el_q[31] ? {32'd0, mag_q} : 65'd0);
        el_d  = {el_q[30:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, span_q}) begin
          rem_d = 32'(rem_sh - {1'b0, span_q});
          quo_d = {quo_q[31:0], 1'b1};
        end else begin
          rem_d = rem_sh[31:0];
          quo_d = {quo_q[31:0], 1'b0};
        end
        acc_d = {acc_q[63:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_d   = sum[31:0];
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    v0_q   <= v0_d;
    span_q <= span_d;
    el_q   <= el_d;
    mag_q  <= mag_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    res_q  <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> design/time_table_linear_interpolator_core.sv
// Append and clear transactions give their result in the cycle after acceptance; busy stays low.
// A query on a non-empty table scans it from a memory with separate read and write ports,
// one entry per cycle, and answers with the entry that decides it, or interpolates between
// that entry and the one before (32 multiply steps and 65 divide steps); busy is high meanwhile.
// Reset clears the entry count and all control state; table contents are undefined until
// written. Results are strobed for one cycle and the receiver cannot stall them.
module time_table_linear_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ttli_pkg::ttli_in_t  req_i,
  output logic               res_valid_o,
  output ttli_pkg::ttli_out_t res_o
);
  import ttli_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_INTERP = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] issue_idx_q, issue_idx_d;
  logic [AW-1:0] cmp_idx_q, cmp_idx_d;
  logic          data_vld_q, data_vld_d;
  logic          res_valid_q, res_valid_d;
  logic [31:0]   stamp_q, stamp_d;
  ttli_entry_t   prev_q, prev_d;
  ttli_out_t     res_q, res_d;

  logic             accept;
  logic             full;
  logic             mem_we;
  ttli_entry_t      mem_wdata;
  logic             rd_en;
  ttli_entry_t      rd_entry;
  logic             hit;
  logic             is_last;
  logic             interp_start;
  ttli_interp_req_t req_x, req_y;
  logic             done_x, done_y;
  logic [31:0]      res_x, res_y;

  assign accept    = start && !busy;
  assign full      = (count_q == CW'(TABLE_DEPTH));
  assign mem_we    = accept && (req_i.mode == MODE_APPEND) && !full;
  assign mem_wdata = '{stamp: req_i.stamp, x: req_i.entry_x, y: req_i.entry_y};
  assign rd_en     = (state_q == S_SCAN) && (issue_idx_q < count_q);
  assign hit       = (rd_entry.stamp >= stamp_q);
  assign is_last   = ((CW'(cmp_idx_q) + CW'(1)) == count_q);
  assign interp_start = (state_q == S_SCAN) && data_vld_q && hit && (cmp_idx_q != '0);

  assign req_x = '{v0: prev_q.x, v1: rd_entry.x,
                   elapsed: stamp_q - prev_q.stamp, span: rd_entry.stamp - prev_q.stamp};
  assign req_y = '{v0: prev_q.y, v1: rd_entry.y,
                   elapsed: stamp_q - prev_q.stamp, span: rd_entry.stamp - prev_q.stamp};

  ttli_table_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (issue_idx_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  ttli_interp_unit u_interp_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (interp_start),
    .req_i   (req_x),
    .done_o  (done_x),
    .res_o   (res_x)
  );

  ttli_interp_unit u_interp_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (interp_start),
    .req_i   (req_y),
    .done_o  (done_y),
    .res_o   (res_y)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_idx_d = issue_idx_q;
    cmp_idx_d   = cmp_idx_q;
    data_vld_d  = 1'b0;
    res_valid_d = 1'b0;
    stamp_d     = stamp_q;
    prev_d      = prev_q;
    res_d       = '{status: ST_POSITION, pos_x: '0, pos_y: '0};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.mode)
            MODE_APPEND: begin
              res_valid_d = 1'b1;
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                res_d.status = ST_STORED;
                count_d      = count_q + CW'(1);
              end
            end
            MODE_QUERY: begin
              if (count_q == '0) begin
                res_valid_d  = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                stamp_d     = req_i.stamp;
                issue_idx_d = '0;
                state_d     = S_SCAN;
              end
            end
            MODE_CLEAR: begin
              res_valid_d  = 1'b1;
              res_d.status = ST_CLEARED;
              count_d      = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          issue_idx_d = issue_idx_q + CW'(1);
          cmp_idx_d   = issue_idx_q[AW-1:0];
          data_vld_d  = 1'b1;
        end
        if (data_vld_q) begin
          if ((hit && (cmp_idx_q == '0)) || (!hit && is_last)) begin
            res_valid_d = 1'b1;
            res_d.pos_x = rd_entry.x;
            res_d.pos_y = rd_entry.y;
            data_vld_d  = 1'b0;
            state_d     = S_IDLE;
          end else if (hit) begin
            data_vld_d = 1'b0;
            state_d    = S_INTERP;
          end else begin
            prev_d = rd_entry;
          end
        end
      end
      S_INTERP: begin
        if (done_x) begin
          res_valid_d = 1'b1;
          res_d.pos_x = res_x;
          res_d.pos_y = res_y;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_idx_q <= '0;
      data_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_idx_q <= issue_idx_d;
      data_vld_q  <= data_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    stamp_q   <= stamp_d;
    prev_q    <= prev_d;
    res_q     <= res_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`include "time_table_linear_interpolator_core_macros.svh"

  `TTLI_ASSERT_IMPL(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= CW'(TABLE_DEPTH))
  `TTLI_ASSERT_IMPL(a_lanes_in_step, clk_i, rst_ni, done_x || done_y, done_x && done_y)
  `TTLI_ASSERT_IMPL(a_zero_pos, clk_i, rst_ni, res_valid_o && (res_o.status != ST_POSITION),
                    (res_o.pos_x == '0) && (res_o.pos_y == '0))
  `TTLI_ASSERT_NEXT(a_quick_result, clk_i, rst_ni,
                    accept && ((req_i.mode == MODE_APPEND) || (req_i.mode == MODE_CLEAR)),
                    res_valid_o && !busy)

endmodule

>>> tb/time_table_linear_interpolator_core_tb.sv
module time_table_linear_interpolator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttli_pkg::*;

  localparam int unsigned DEPTH = 256;
  localparam int unsigned ITEM_TARGET = 1800;

  class interp_scoreboard;
    logic [31:0] table_time [DEPTH];
    logic [31:0] table_x [DEPTH];
    logic [31:0] table_y [DEPTH];
    int unsigned entry_count;
    ttli_out_t   expected_answers[$];
    int unsigned errors;

    function new();
      entry_count = 0;
      errors = 0;
    endfunction

    function automatic logic [31:0] blend(logic [31:0] v0, logic [31:0] v1,
                                          logic [31:0] elapsed, logic [31:0] span);
      logic signed [33:0] a;
      logic signed [33:0] b;
      logic signed [33:0] diff;
      logic [63:0] mag;
      logic [63:0] quo;
      if (span == 0) begin
        return v0;
      end
      a = {{2{v0[31]}}, v0};
      b = {{2{v1[31]}}, v1};
      diff = b - a;
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      quo = (mag * {32'b0, elapsed}) / {32'b0, span};
      return (diff < 0) ? (v0 - quo[31:0]) : (v0 + quo[31:0]);
    endfunction

    function void note_request(ttli_in_t rq);
      ttli_out_t ans;
      int unsigned k;
      logic [31:0] t0;
      ans = '0;
      case (rq.mode)
        MODE_APPEND: begin
          if (entry_count >= DEPTH) begin
            ans.status = ST_FULL;
          end else begin
            table_time[entry_count] = rq.stamp;
            table_x[entry_count] = rq.entry_x;
            table_y[entry_count] = rq.entry_y;
            entry_count++;
            ans.status = ST_STORED;
          end
        end
        MODE_CLEAR: begin
          entry_count = 0;
          ans.status = ST_CLEARED;
        end
        MODE_QUERY: begin
          if (entry_count == 0) begin
            ans.status = ST_EMPTY;
          end else begin
            k = 0;
            while (k < entry_count && table_time[k] < rq.stamp) k++;
            ans.status = ST_POSITION;
            if (k == entry_count) begin
              ans.pos_x = table_x[entry_count-1];
              ans.pos_y = table_y[entry_count-1];
            end else if (k == 0) begin
              ans.pos_x = table_x[0];
              ans.pos_y = table_y[0];
            end else begin
              t0 = table_time[k-1];
              ans.pos_x = blend(table_x[k-1], table_x[k], rq.stamp - t0,
                                table_time[k] - t0);
              ans.pos_y = blend(table_y[k-1], table_y[k], rq.stamp - t0,
                                table_time[k] - t0);
            end
          end
        end
        default: return;
      endcase
      expected_answers = {expected_answers, ans};
    endfunction

    function void check_answer(ttli_out_t got);
      ttli_out_t want;
      if (expected_answers.size() == 0) begin
        $error("unexpected result: status %0d pos_x %0d pos_y %0d",
               got.status, got.pos_x, got.pos_y);
        errors++;
        return;
      end
      want = expected_answers.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x: expected %0d, actual %0d", want.pos_x, got.pos_x);
        errors++;
      end
      if (got.pos_y !== want.pos_y) begin
        $error("pos_y: expected %0d, actual %0d", want.pos_y, got.pos_y);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_answers.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  ttli_in_t  req_i = '0;
  logic      res_valid_o;
  ttli_out_t res_o;

  interp_scoreboard sb;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 14;
  logic [31:0] session_times[$];

  time_table_linear_interpolator_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("time_table_linear_interpolator_core_tb: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) sb.check_answer(res_o);
      if (start && !busy) sb.note_request(req_i);
    end
  end

  task automatic issue(logic [1:0] mode, logic [31:0] stamp, logic [31:0] x,
                       logic [31:0] y);
    ttli_in_t rq;
    rq.mode = mode;
    rq.stamp = stamp;
    rq.entry_x = x;
    rq.entry_y = y;
    req_i <= rq;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (mode != 2'd3) items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_stamp();
    int unsigned idx;
    if (session_times.size() == 0) return $urandom;
    idx = $urandom_range(session_times.size() - 1);
    case ($urandom_range(7))
      0: return session_times[idx];
      1: return session_times[idx] + 1;
      2: return session_times[idx] - 1;
      3: return session_times[idx] + $urandom_range(1000);
      4: return 32'h0;
      5: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_session(ref int unsigned full_fills);
    int unsigned n;
    int unsigned q;
    logic [31:0] t;
    bit ordered;
    if ($urandom_range(99) < 80) issue(MODE_CLEAR, $urandom, $urandom, $urandom);
    session_times.delete();
    if ($urandom_range(99) < 3 && full_fills < 2) begin
      n = DEPTH + $urandom_range(1, 3);
      full_fills++;
    end else begin
      n = $urandom_range(1, 12);
    end
    ordered = ($urandom_range(9) != 0);
    case ($urandom_range(4))
      0: t = 32'h0;
      1: t = 32'hFFFF_0000;
      default: t = $urandom_range(100000);
    endcase
    for (int unsigned i = 0; i < n; i++) begin
      if (!ordered) begin
        t = $urandom;
      end else if (i != 0) begin
        case ($urandom_range(9))
          0: t = t;
          1: t = t + $urandom;
          default: t = t + $urandom_range(1, 5000);
        endcase
      end
      session_times = {session_times, t};
      issue(MODE_APPEND, t, pick_coord(), pick_coord());
    end
    q = (n > 12) ? $urandom_range(1, 3) : $urandom_range(1, 6);
    for (int unsigned i = 0; i < q; i++) begin
      issue(MODE_QUERY, pick_stamp(), $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned full_fills;
    int unsigned phase;
    int unsigned last_phase;
    sb = new();
    full_fills = 0;
    last_phase = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(MODE_QUERY, 32'd1000, 32'h0, 32'h0);
    issue(MODE_CLEAR, 32'h0, 32'h0, 32'h0);
    issue(2'd3, 32'h0, 32'h0, 32'h0);
    issue(MODE_APPEND, 32'd100, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(MODE_APPEND, 32'd200, 32'h7FFF_FFFF, 32'h8000_0000);
    issue(MODE_QUERY, 32'd0, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'd100, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'd150, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'd101, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'd199, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'd200, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'hFFFF_FFFF, 32'h0, 32'h0);
    issue(MODE_APPEND, 32'd200, 32'h0, 32'h0);
    issue(MODE_APPEND, 32'd50, 32'hFFFF_FFFF, 32'h1);
    issue(MODE_QUERY, 32'd200, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'd60, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'd250, 32'h0, 32'h0);
    issue(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(MODE_QUERY, 32'd5, 32'h0, 32'h0);
    issue(MODE_APPEND, 32'h0, 32'h0, 32'h0);
    issue(MODE_APPEND, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    issue(MODE_QUERY, 32'd1, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'hFFFF_FFFE, 32'h0, 32'h0);
    issue(MODE_QUERY, 32'h8000_0000, 32'h0, 32'h0);
    issue(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      phase = items_sent / (ITEM_TARGET / 3);
      if (phase != last_phase) begin
        drain();
        last_phase = phase;
      end
      case (phase)
        0: idle_pct = 14;
        1: idle_pct = 83;
        default: idle_pct = 0;
      endcase
      if ($urandom_range(99) < 8) begin
        issue(2'($urandom_range(3)), $urandom, $urandom, $urandom);
      end else begin
        run_session(full_fills);
      end
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("time_table_linear_interpolator_core_tb: clean");
    end else begin
      $display("time_table_linear_interpolator_core_tb: errors");
    end
    $finish;
  end

endmodule
